// ===== design/lbs_pkg.sv =====
// Shared types and constants for the BAOAB Langevin step core.
// Used by lbs_ctrl, lbs_lane, lbs_merge and langevin_baoab_step_core; depends on nothing.
package lbs_pkg;

  localparam int DATA_W     = 32;
  localparam int NOISE_W    = 16;
  localparam int DECAY_W    = 16;
  localparam int DECAY_BITS = 16;
  // signed working width for products plus rounding and accumulation
  localparam int PROD_W     = 66;
  localparam int SQ_W       = 64;
  // width of half_mass times sum of squares plus rounding
  localparam int KE_W       = 97;
  localparam int CFG_IDX_W  = 3;

  // action codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_STEP  = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KICK_SCALE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_DT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_MASS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_X     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_START_Z     = 3'd7;

  // configuration reset values
  localparam logic [DATA_W-1:0]  RST_KICK_SCALE  = 32'd1365;
  localparam logic [DATA_W-1:0]  RST_HALF_DT     = 32'd16384;
  localparam logic [DECAY_W-1:0] RST_DECAY       = 16'd442;
  localparam logic [DATA_W-1:0]  RST_NOISE_SCALE = 32'd14603;
  localparam logic [DATA_W-1:0]  RST_HALF_MASS   = 32'd393216;
  localparam logic [DATA_W-1:0]  RST_START_X     = 32'hFFFB_0000;
  localparam logic [DATA_W-1:0]  RST_START_Y     = 32'hFFFB_0000;
  localparam logic [DATA_W-1:0]  RST_START_Z     = 32'h0000_0000;

  typedef struct packed {
    logic [1:0]                 action;
    logic signed [DATA_W-1:0]   start_vel_x;
    logic signed [DATA_W-1:0]   start_vel_y;
    logic signed [DATA_W-1:0]   start_vel_z;
    logic signed [DATA_W-1:0]   force_x;
    logic signed [DATA_W-1:0]   force_y;
    logic signed [DATA_W-1:0]   force_z;
    logic signed [NOISE_W-1:0]  noise_x;
    logic signed [NOISE_W-1:0]  noise_y;
    logic signed [NOISE_W-1:0]  noise_z;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
    logic [DATA_W-1:0]        kinetic_energy;
  } out_item_t;

  // per-axis lane operations
  typedef enum logic [3:0] {
    LOP_NONE,
    LOP_LOAD,
    LOP_CAPTURE,
    LOP_KICK_MUL,
    LOP_KICK_ACC,
    LOP_DRIFT_MUL,
    LOP_DRIFT_ACC,
    LOP_THERM_MUL,
    LOP_THERM_ACC,
    LOP_SQ_MUL
  } lane_op_t;

  // kinetic energy merge operations
  typedef enum logic [1:0] {
    MOP_NONE,
    MOP_SUM,
    MOP_MUL_LO,
    MOP_MUL_HI
  } merge_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_PK_MUL,
    S_PK_ACC,
    S_CAPTURE,
    S_K_MUL,
    S_K_ACC,
    S_D1_MUL,
    S_D1_ACC,
    S_T_MUL,
    S_T_ACC,
    S_D2_MUL,
    S_D2_ACC,
    S_SQ,
    S_SUM,
    S_KE_LO,
    S_KE_HI,
    S_FIN
  } ctrl_state_t;

  typedef struct packed {
    lane_op_t  lane_op;
    merge_op_t merge_op;
    logic      out_load;
  } lbs_ctrl_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] val);
    if ((&val[PROD_W-1:DATA_W-1]) || (~|val[PROD_W-1:DATA_W-1]))
      return val[DATA_W-1:0];
    else if (val[PROD_W-1])
      return {1'b1, {(DATA_W-1){1'b0}}};
    else
      return {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

endpackage

// ===== design/lbs_ctrl.sv =====
// Sequencer for the BAOAB step core: walks one word through kick, drift,
// thermostat and kinetic energy steps. Depends on lbs_pkg.
module lbs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic [1:0]        action,
  input  logic              result_valid,
  input  logic              result_ready,
  output logic              item_ready,
  output lbs_pkg::lbs_ctrl_t ctl
);

  lbs_pkg::ctrl_state_t state, state_next;
  logic                 kick_pending;
  logic [1:0]           act;
  logic                 accept;
  logic                 out_free;

  assign item_ready = (state == lbs_pkg::S_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;

  // state, pending half kick and held action
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lbs_pkg::S_IDLE;
      kick_pending <= 1'b0;
      act          <= lbs_pkg::ACT_START;
    end else begin
      state <= state_next;
      if (accept) begin
        act <= action;
        case (action)
          lbs_pkg::ACT_START: kick_pending <= 1'b0;
          lbs_pkg::ACT_STEP:  kick_pending <= 1'b1;
          lbs_pkg::ACT_CLOSE: kick_pending <= 1'b0;
          default:            kick_pending <= kick_pending;
        endcase
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lbs_pkg::S_IDLE: begin
        if (accept) begin
          if (action == lbs_pkg::ACT_START)
            state_next = lbs_pkg::S_LOAD;
          else if ((action == lbs_pkg::ACT_STEP || action == lbs_pkg::ACT_CLOSE) && kick_pending)
            state_next = lbs_pkg::S_PK_MUL;
          else
            state_next = lbs_pkg::S_CAPTURE;
        end
      end
      lbs_pkg::S_LOAD:    state_next = lbs_pkg::S_CAPTURE;
      lbs_pkg::S_PK_MUL:  state_next = lbs_pkg::S_PK_ACC;
      lbs_pkg::S_PK_ACC:  state_next = lbs_pkg::S_CAPTURE;
      lbs_pkg::S_CAPTURE: begin
        state_next = (act == lbs_pkg::ACT_STEP) ? lbs_pkg::S_K_MUL : lbs_pkg::S_SQ;
      end
      lbs_pkg::S_K_MUL:   state_next = lbs_pkg::S_K_ACC;
      lbs_pkg::S_K_ACC:   state_next = lbs_pkg::S_D1_MUL;
      lbs_pkg::S_D1_MUL:  state_next = lbs_pkg::S_D1_ACC;
      lbs_pkg::S_D1_ACC:  state_next = lbs_pkg::S_T_MUL;
      lbs_pkg::S_T_MUL:   state_next = lbs_pkg::S_T_ACC;
      lbs_pkg::S_T_ACC:   state_next = lbs_pkg::S_D2_MUL;
      lbs_pkg::S_D2_MUL:  state_next = lbs_pkg::S_D2_ACC;
      lbs_pkg::S_D2_ACC:  state_next = lbs_pkg::S_SQ;
      lbs_pkg::S_SQ:      state_next = lbs_pkg::S_SUM;
      lbs_pkg::S_SUM:     state_next = lbs_pkg::S_KE_LO;
      lbs_pkg::S_KE_LO:   state_next = lbs_pkg::S_KE_HI;
      lbs_pkg::S_KE_HI:   state_next = lbs_pkg::S_FIN;
      lbs_pkg::S_FIN: begin
        if (out_free)
          state_next = lbs_pkg::S_IDLE;
      end
      default:            state_next = lbs_pkg::S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    ctl.lane_op  = lbs_pkg::LOP_NONE;
    ctl.merge_op = lbs_pkg::MOP_NONE;
    ctl.out_load = 1'b0;
    case (state)
      lbs_pkg::S_LOAD:    ctl.lane_op = lbs_pkg::LOP_LOAD;
      lbs_pkg::S_PK_MUL:  ctl.lane_op = lbs_pkg::LOP_KICK_MUL;
      lbs_pkg::S_PK_ACC:  ctl.lane_op = lbs_pkg::LOP_KICK_ACC;
      lbs_pkg::S_CAPTURE: ctl.lane_op = lbs_pkg::LOP_CAPTURE;
      lbs_pkg::S_K_MUL:   ctl.lane_op = lbs_pkg::LOP_KICK_MUL;
      lbs_pkg::S_K_ACC:   ctl.lane_op = lbs_pkg::LOP_KICK_ACC;
      lbs_pkg::S_D1_MUL:  ctl.lane_op = lbs_pkg::LOP_DRIFT_MUL;
      lbs_pkg::S_D1_ACC:  ctl.lane_op = lbs_pkg::LOP_DRIFT_ACC;
      lbs_pkg::S_T_MUL:   ctl.lane_op = lbs_pkg::LOP_THERM_MUL;
      lbs_pkg::S_T_ACC:   ctl.lane_op = lbs_pkg::LOP_THERM_ACC;
      lbs_pkg::S_D2_MUL:  ctl.lane_op = lbs_pkg::LOP_DRIFT_MUL;
      lbs_pkg::S_D2_ACC:  ctl.lane_op = lbs_pkg::LOP_DRIFT_ACC;
      lbs_pkg::S_SQ:      ctl.lane_op = lbs_pkg::LOP_SQ_MUL;
      lbs_pkg::S_SUM:     ctl.merge_op = lbs_pkg::MOP_SUM;
      lbs_pkg::S_KE_LO:   ctl.merge_op = lbs_pkg::MOP_MUL_LO;
      lbs_pkg::S_KE_HI:   ctl.merge_op = lbs_pkg::MOP_MUL_HI;
      lbs_pkg::S_FIN:     ctl.out_load = out_free;
      default:            ctl.lane_op = lbs_pkg::LOP_NONE;
    endcase
  end

endmodule

// ===== design/lbs_lane.sv =====
// One axis of the BAOAB step: position and velocity state, one shared
// multiplier plus the noise multiplier, rounding and saturation. Depends on lbs_pkg.
module lbs_lane #(
  parameter int FRAC_BITS       = 16,
  parameter int NOISE_FRAC_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lbs_pkg::lane_op_t                     op,
  input  logic [lbs_pkg::DATA_W-1:0]            kick_scale,
  input  logic [lbs_pkg::DATA_W-1:0]            half_dt,
  input  logic [lbs_pkg::DECAY_W-1:0]           decay,
  input  logic [lbs_pkg::DATA_W-1:0]            noise_scale,
  input  logic signed [lbs_pkg::DATA_W-1:0]     start_pos,
  input  logic signed [lbs_pkg::DATA_W-1:0]     start_vel,
  input  logic signed [lbs_pkg::DATA_W-1:0]     frc,
  input  logic signed [lbs_pkg::NOISE_W-1:0]    noise,
  output logic signed [lbs_pkg::DATA_W-1:0]     pos,
  output logic signed [lbs_pkg::DATA_W-1:0]     cvel,
  output logic [lbs_pkg::SQ_W-1:0]              sq
);

  localparam int PW          = lbs_pkg::PROD_W;
  localparam int DW          = lbs_pkg::DATA_W;
  localparam int NW          = lbs_pkg::NOISE_W;
  localparam int NOISE_SHIFT = lbs_pkg::DECAY_BITS - NOISE_FRAC_BITS;
  localparam logic signed [PW-1:0] HALF_F = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] HALF_D =
    {{(PW-1){1'b0}}, 1'b1} << (lbs_pkg::DECAY_BITS - 1);

  logic signed [DW-1:0]      x, v;
  logic signed [DW:0]        mul_a;
  logic signed [DW-1:0]      mul_b;
  logic signed [2*DW:0]      mul_p;
  logic signed [DW+NW:0]     noise_p;
  logic signed [PW-1:0]      prod_a, prod_b;
  logic signed [PW-1:0]      kick_sum, drift_sum, therm_sum;

  assign pos = x;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      lbs_pkg::LOP_KICK_MUL: begin
        mul_a = $signed({1'b0, kick_scale});
        mul_b = frc;
      end
      lbs_pkg::LOP_DRIFT_MUL: begin
        mul_a = $signed({1'b0, half_dt});
        mul_b = v;
      end
      lbs_pkg::LOP_THERM_MUL: begin
        mul_a = $signed({{(DW + 1 - lbs_pkg::DECAY_W){1'b0}}, decay});
        mul_b = v;
      end
      lbs_pkg::LOP_SQ_MUL: begin
        mul_a = {v[DW-1], v};
        mul_b = v;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign noise_p = $signed({1'b0, noise_scale}) * noise;

  // round half up, then add; the thermostat adds both products before rounding
  assign kick_sum  = PW'(v) + ((prod_a + HALF_F) >>> FRAC_BITS);
  assign drift_sum = PW'(x) + ((prod_a + HALF_F) >>> FRAC_BITS);
  assign therm_sum = (prod_a + prod_b + HALF_D) >>> lbs_pkg::DECAY_BITS;

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      x <= '0;
      v <= '0;
    end else begin
      case (op)
        lbs_pkg::LOP_LOAD: begin
          x <= start_pos;
          v <= start_vel;
        end
        lbs_pkg::LOP_KICK_ACC:  v <= lbs_pkg::sat32(kick_sum);
        lbs_pkg::LOP_DRIFT_ACC: x <= lbs_pkg::sat32(drift_sum);
        lbs_pkg::LOP_THERM_ACC: v <= lbs_pkg::sat32(therm_sum);
        default: begin
          x <= x;
          v <= v;
        end
      endcase
    end
  end

  // product registers and captured velocity
  always_ff @(posedge clk) begin
    case (op)
      lbs_pkg::LOP_KICK_MUL:  prod_a <= PW'(mul_p);
      lbs_pkg::LOP_DRIFT_MUL: prod_a <= PW'(mul_p);
      lbs_pkg::LOP_THERM_MUL: begin
        prod_a <= PW'(mul_p);
        prod_b <= PW'(noise_p) <<< NOISE_SHIFT;
      end
      lbs_pkg::LOP_SQ_MUL:    sq   <= mul_p[lbs_pkg::SQ_W-1:0];
      lbs_pkg::LOP_CAPTURE:   cvel <= v;
      default:                prod_a <= prod_a;
    endcase
  end

endmodule

// ===== design/lbs_merge.sv =====
// Merge stage: sums the three lane squares and scales by half_mass into a
// rounded, saturated kinetic energy. Depends on lbs_pkg.
module lbs_merge #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  lbs_pkg::merge_op_t            op,
  input  logic [lbs_pkg::DATA_W-1:0]    half_mass,
  input  logic [lbs_pkg::SQ_W-1:0]      sq_x,
  input  logic [lbs_pkg::SQ_W-1:0]      sq_y,
  input  logic [lbs_pkg::SQ_W-1:0]      sq_z,
  output logic [lbs_pkg::DATA_W-1:0]    ke
);

  localparam int DW       = lbs_pkg::DATA_W;
  localparam int KW       = lbs_pkg::KE_W;
  localparam int KE_SHIFT = 2 * FRAC_BITS;
  localparam logic [KW-1:0] KE_HALF = {{(KW-1){1'b0}}, 1'b1} << (KE_SHIFT - 1);

  logic [lbs_pkg::SQ_W-1:0] acc, p_lo, p_hi, mul_p;
  logic [DW-1:0]            mul_x;
  logic [KW-1:0]            total, scaled;

  // one 32x32 multiplier, used for the low and high halves in turn
  assign mul_x = (op == lbs_pkg::MOP_MUL_HI) ? acc[2*DW-1:DW] : acc[DW-1:0];
  assign mul_p = mul_x * half_mass;

  always_ff @(posedge clk) begin
    case (op)
      lbs_pkg::MOP_SUM:    acc  <= sq_x + sq_y + sq_z;
      lbs_pkg::MOP_MUL_LO: p_lo <= mul_p;
      lbs_pkg::MOP_MUL_HI: p_hi <= mul_p;
      default:             acc  <= acc;
    endcase
  end

  // recombine halves, round half up, saturate to 32 bits
  assign total  = KW'(p_lo) + (KW'(p_hi) << DW) + KE_HALF;
  assign scaled = total >> KE_SHIFT;
  assign ke     = (|scaled[KW-1:DW]) ? {DW{1'b1}} : scaled[DW-1:0];

endmodule

// ===== design/langevin_baoab_step_core.sv =====
// Top level of the three-axis BAOAB Langevin step core; instantiates lbs_ctrl,
// three lbs_lane and lbs_merge. Depends on lbs_pkg.
//
// One word in gives one word out. A step word first finishes the previous
// step's half kick if one is pending, then kicks, drifts, thermostats and
// drifts; a start word first loads the lanes, and a close word finishes a
// pending kick. Each axis lane owns one shared multiplier plus the noise
// multiplier and does each multiply-add as a product register, then round,
// add, saturate; the kinetic energy merge adds the sum and the two halves of
// the half_mass product. The result register holds a finished word while the
// next word is taken. Configuration writes are taken every cycle and must be
// made while no word is in flight. No clearing pass after reset.
module langevin_baoab_step_core #(
  parameter int FRAC_BITS       = 16,
  parameter int NOISE_FRAC_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  lbs_pkg::in_item_t                 item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output lbs_pkg::out_item_t                result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lbs_pkg::DATA_W-1:0]        cfg_data
);

  localparam int DW = lbs_pkg::DATA_W;

  logic [DW-1:0]               kick_scale, half_dt, noise_scale, half_mass;
  logic [lbs_pkg::DECAY_W-1:0] decay;
  logic [DW-1:0]               start_x, start_y, start_z;
  lbs_pkg::in_item_t           item_q;
  lbs_pkg::lbs_ctrl_t          ctl;
  logic signed [DW-1:0]        pos_x, pos_y, pos_z, cv_x, cv_y, cv_z;
  logic [lbs_pkg::SQ_W-1:0]    sq_x, sq_y, sq_z;
  logic [DW-1:0]               ke;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kick_scale  <= lbs_pkg::RST_KICK_SCALE;
      half_dt     <= lbs_pkg::RST_HALF_DT;
      decay       <= lbs_pkg::RST_DECAY;
      noise_scale <= lbs_pkg::RST_NOISE_SCALE;
      half_mass   <= lbs_pkg::RST_HALF_MASS;
      start_x     <= lbs_pkg::RST_START_X;
      start_y     <= lbs_pkg::RST_START_Y;
      start_z     <= lbs_pkg::RST_START_Z;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lbs_pkg::REG_KICK_SCALE:  kick_scale  <= cfg_data;
        lbs_pkg::REG_HALF_DT:     half_dt     <= cfg_data;
        lbs_pkg::REG_DECAY:       decay       <= cfg_data[lbs_pkg::DECAY_W-1:0];
        lbs_pkg::REG_NOISE_SCALE: noise_scale <= cfg_data;
        lbs_pkg::REG_HALF_MASS:   half_mass   <= cfg_data;
        lbs_pkg::REG_START_X:     start_x     <= cfg_data;
        lbs_pkg::REG_START_Y:     start_y     <= cfg_data;
        lbs_pkg::REG_START_Z:     start_z     <= cfg_data;
        default:                  kick_scale  <= kick_scale;
      endcase
    end
  end

  // hold the accepted word for the whole sequence
  always_ff @(posedge clk) begin
    if (item_valid && item_ready)
      item_q <= item;
  end

  lbs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .action       (item.action),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .item_ready   (item_ready),
    .ctl          (ctl)
  );

  lbs_lane #(.FRAC_BITS(FRAC_BITS), .NOISE_FRAC_BITS(NOISE_FRAC_BITS)) u_lane_x (
    .clk         (clk),
    .rst         (rst),
    .op          (ctl.lane_op),
    .kick_scale  (kick_scale),
    .half_dt     (half_dt),
    .decay       (decay),
    .noise_scale (noise_scale),
    .start_pos   ($signed(start_x)),
    .start_vel   (item_q.start_vel_x),
    .frc         (item_q.force_x),
    .noise       (item_q.noise_x),
    .pos         (pos_x),
    .cvel        (cv_x),
    .sq          (sq_x)
  );

  lbs_lane #(.FRAC_BITS(FRAC_BITS), .NOISE_FRAC_BITS(NOISE_FRAC_BITS)) u_lane_y (
    .clk         (clk),
    .rst         (rst),
    .op          (ctl.lane_op),
    .kick_scale  (kick_scale),
    .half_dt     (half_dt),
    .decay       (decay),
    .noise_scale (noise_scale),
    .start_pos   ($signed(start_y)),
    .start_vel   (item_q.start_vel_y),
    .frc         (item_q.force_y),
    .noise       (item_q.noise_y),
    .pos         (pos_y),
    .cvel        (cv_y),
    .sq          (sq_y)
  );

  lbs_lane #(.FRAC_BITS(FRAC_BITS), .NOISE_FRAC_BITS(NOISE_FRAC_BITS)) u_lane_z (
    .clk         (clk),
    .rst         (rst),
    .op          (ctl.lane_op),
    .kick_scale  (kick_scale),
    .half_dt     (half_dt),
    .decay       (decay),
    .noise_scale (noise_scale),
    .start_pos   ($signed(start_z)),
    .start_vel   (item_q.start_vel_z),
    .frc         (item_q.force_z),
    .noise       (item_q.noise_z),
    .pos         (pos_z),
    .cvel        (cv_z),
    .sq          (sq_z)
  );

  lbs_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk       (clk),
    .op        (ctl.merge_op),
    .half_mass (half_mass),
    .sq_x      (sq_x),
    .sq_y      (sq_y),
    .sq_z      (sq_z),
    .ke        (ke)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      result.pos_x          <= pos_x;
      result.pos_y          <= pos_y;
      result.pos_z          <= pos_z;
      result.vel_x          <= cv_x;
      result.vel_y          <= cv_y;
      result.vel_z          <= cv_z;
      result.kinetic_energy <= ke;
    end
  end

  // a finished word always reaches the result register
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |=> result_valid)
    else $error("loaded result not presented");

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !ctl.out_load)
    else $error("pending result overwritten");

  // no new word while a lane is busy
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (ctl.lane_op != lbs_pkg::LOP_NONE) |-> !item_ready)
    else $error("word accepted while lanes busy");

  // a start word loads the lanes next
  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item.action == lbs_pkg::ACT_START)
      |=> (ctl.lane_op == lbs_pkg::LOP_LOAD))
    else $error("start word did not load state");

endmodule

// ===== bench/langevin_step_checker.sv =====
// Checker for langevin_baoab_step_core: watches the word, result and config channels,
// keeps its own fixed-point BAOAB particle state and compares every result word.
// Depends on lbs_pkg.
module langevin_step_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_ready,
  input  lbs_pkg::in_item_t             item,
  input  logic                          result_valid,
  input  logic                          result_ready,
  input  lbs_pkg::out_item_t            result,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [lbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbs_pkg::DATA_W-1:0]    cfg_data,
  output int                            mismatches,
  output int                            outstanding
);

  localparam int FRAC       = 16;
  localparam int NOISE_FRAC = 12;

  typedef logic signed [127:0] wide_t;

  // register copies
  logic [31:0]        kick_scale_q;
  logic [31:0]        half_dt_q;
  logic [15:0]        decay_q;
  logic [31:0]        noise_scale_q;
  logic [31:0]        half_mass_q;
  logic signed [31:0] start_pos [3];

  // particle state
  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic               kick_open;

  lbs_pkg::out_item_t expected_words [$];
  int                 fail_cnt = 0;

  assign mismatches = fail_cnt;

  function automatic wide_t sgn_w(input logic signed [31:0] v);
    return wide_t'(v);
  endfunction

  function automatic wide_t uns_w(input logic [31:0] u);
    return {96'd0, u};
  endfunction

  // add half an lsb, then floor
  function automatic wide_t round_q(input wide_t p, input int s);
    return (p + (wide_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(input wide_t v);
    if (v > sgn_w(32'sh7FFF_FFFF))
      return 32'sh7FFF_FFFF;
    if (v < sgn_w(32'sh8000_0000))
      return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] half_kick(input logic signed [31:0] v,
                                                   input logic signed [31:0] f);
    return clamp32(sgn_w(v) + round_q(uns_w(kick_scale_q) * sgn_w(f), FRAC));
  endfunction

  function automatic logic signed [31:0] half_drift(input logic signed [31:0] x,
                                                    input logic signed [31:0] v);
    return clamp32(sgn_w(x) + round_q(uns_w(half_dt_q) * sgn_w(v), FRAC));
  endfunction

  // v = decay*v + noise_scale*noise, noise aligned to the decay fraction
  function automatic logic signed [31:0] thermostat(input logic signed [31:0] v,
                                                    input logic signed [31:0] n);
    wide_t damped, kicked;
    damped = uns_w({16'd0, decay_q}) * sgn_w(v);
    kicked = (uns_w(noise_scale_q) * sgn_w(n)) <<< (lbs_pkg::DECAY_BITS - NOISE_FRAC);
    return clamp32(round_q(damped + kicked, lbs_pkg::DECAY_BITS));
  endfunction

  // advance the particle by one word and build the result it must give
  task automatic integrate_word(input lbs_pkg::in_item_t w, output lbs_pkg::out_item_t r);
    logic signed [31:0] frc [3];
    logic signed [31:0] nse [3];
    logic signed [31:0] done_vel [3];
    wide_t              sq_sum;
    wide_t              scaled;
    frc[0] = w.force_x;
    frc[1] = w.force_y;
    frc[2] = w.force_z;
    nse[0] = w.noise_x;
    nse[1] = w.noise_y;
    nse[2] = w.noise_z;
    if (w.action == lbs_pkg::ACT_START) begin
      for (int a = 0; a < 3; a++)
        pos[a] = start_pos[a];
      vel[0] = w.start_vel_x;
      vel[1] = w.start_vel_y;
      vel[2] = w.start_vel_z;
      kick_open = 1'b0;
    end else if (w.action == lbs_pkg::ACT_STEP || w.action == lbs_pkg::ACT_CLOSE) begin
      // finish the previous step's half kick
      if (kick_open)
        for (int a = 0; a < 3; a++)
          vel[a] = half_kick(vel[a], frc[a]);
      kick_open = 1'b0;
    end
    for (int a = 0; a < 3; a++)
      done_vel[a] = vel[a];
    if (w.action == lbs_pkg::ACT_STEP) begin
      for (int a = 0; a < 3; a++) begin
        vel[a] = half_kick(vel[a], frc[a]);
        pos[a] = half_drift(pos[a], vel[a]);
        vel[a] = thermostat(vel[a], nse[a]);
        pos[a] = half_drift(pos[a], vel[a]);
      end
      kick_open = 1'b1;
    end
    // kinetic energy from the held velocities, exact then rounded
    sq_sum = '0;
    for (int a = 0; a < 3; a++)
      sq_sum = sq_sum + sgn_w(vel[a]) * sgn_w(vel[a]);
    scaled = round_q(uns_w(half_mass_q) * sq_sum, 2 * FRAC);
    r.pos_x = pos[0];
    r.pos_y = pos[1];
    r.pos_z = pos[2];
    r.vel_x = done_vel[0];
    r.vel_y = done_vel[1];
    r.vel_z = done_vel[2];
    r.kinetic_energy = (scaled > uns_w(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : scaled[31:0];
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    lbs_pkg::out_item_t want;
    if (rst) begin
      kick_scale_q  = lbs_pkg::RST_KICK_SCALE;
      half_dt_q     = lbs_pkg::RST_HALF_DT;
      decay_q       = lbs_pkg::RST_DECAY;
      noise_scale_q = lbs_pkg::RST_NOISE_SCALE;
      half_mass_q   = lbs_pkg::RST_HALF_MASS;
      start_pos[0]  = lbs_pkg::RST_START_X;
      start_pos[1]  = lbs_pkg::RST_START_Y;
      start_pos[2]  = lbs_pkg::RST_START_Z;
      for (int a = 0; a < 3; a++) begin
        pos[a] = '0;
        vel[a] = '0;
      end
      kick_open = 1'b0;
      expected_words.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lbs_pkg::REG_KICK_SCALE:  kick_scale_q  = cfg_data;
          lbs_pkg::REG_HALF_DT:     half_dt_q     = cfg_data;
          lbs_pkg::REG_DECAY:       decay_q       = cfg_data[15:0];
          lbs_pkg::REG_NOISE_SCALE: noise_scale_q = cfg_data;
          lbs_pkg::REG_HALF_MASS:   half_mass_q   = cfg_data;
          lbs_pkg::REG_START_X:     start_pos[0]  = cfg_data;
          lbs_pkg::REG_START_Y:     start_pos[1]  = cfg_data;
          lbs_pkg::REG_START_Z:     start_pos[2]  = cfg_data;
          default: ;
        endcase
      end
      // compare a taken result with the oldest prediction
      if (result_valid && result_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with none expected, actual %h", $time, result);
          fail_cnt++;
        end else begin
          want = expected_words.pop_front();
          check_field("pos_x", want.pos_x, result.pos_x);
          check_field("pos_y", want.pos_y, result.pos_y);
          check_field("pos_z", want.pos_z, result.pos_z);
          check_field("vel_x", want.vel_x, result.vel_x);
          check_field("vel_y", want.vel_y, result.vel_y);
          check_field("vel_z", want.vel_z, result.vel_z);
          check_field("kinetic_energy", want.kinetic_energy, result.kinetic_energy);
        end
      end
      // predict for a taken input word
      if (item_valid && item_ready) begin
        integrate_word(item, want);
        expected_words.push_back(want);
      end
    end
    outstanding <= expected_words.size();
  end

endmodule

// ===== bench/tb_langevin_baoab_step_core.sv =====
// Testbench top for langevin_baoab_step_core: clock, reset, config phases and
// directed plus random word streams; checking is done by langevin_step_checker.
// Depends on lbs_pkg, langevin_step_checker and the core.
module tb_langevin_baoab_step_core;

  localparam logic [1:0] ACT_UNUSED    = 2'd3;
  localparam int         CYCLE_LIMIT   = 500000;
  localparam int         SETTLE_CYCLES = 20;

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          item_valid   = 1'b0;
  logic                          item_ready;
  lbs_pkg::in_item_t             item         = '0;
  logic                          result_valid;
  logic                          result_ready = 1'b0;
  lbs_pkg::out_item_t            result;
  logic                          cfg_valid    = 1'b0;
  logic                          cfg_ready;
  logic [lbs_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
  logic [lbs_pkg::DATA_W-1:0]    cfg_data     = '0;

  logic send_idle = 1'b0;
  logic take_idle = 1'b0;
  int   errors;
  int   outstanding;
  int   cycle_count = 0;

  langevin_baoab_step_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  langevin_step_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (errors),
    .outstanding  (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Q16.16 value: mostly moderate, sometimes the extremes or any pattern
  function automatic logic [31:0] pick_q16();
    case ($urandom_range(11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom();
      4, 5:    return $urandom_range(0, 32'h0000_8000) - 32'h0000_4000;
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  // Q4.12 noise sample
  function automatic logic [15:0] pick_noise();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom());
      default: return 16'($urandom_range(0, 24576) - 12288);
    endcase
  endfunction

  function automatic lbs_pkg::in_item_t random_word(input logic [1:0] act);
    lbs_pkg::in_item_t w;
    w.action      = act;
    w.start_vel_x = pick_q16();
    w.start_vel_y = pick_q16();
    w.start_vel_z = pick_q16();
    w.force_x     = pick_q16();
    w.force_y     = pick_q16();
    w.force_z     = pick_q16();
    w.noise_x     = pick_noise();
    w.noise_y     = pick_noise();
    w.noise_z     = pick_noise();
    return w;
  endfunction

  // y axis gets the complement so both extremes show up together
  function automatic lbs_pkg::in_item_t directed_word(input logic [1:0] act,
                                                      input logic [31:0] v,
                                                      input logic [31:0] f,
                                                      input logic [15:0] n);
    lbs_pkg::in_item_t w;
    w.action      = act;
    w.start_vel_x = v;
    w.start_vel_y = ~v;
    w.start_vel_z = v;
    w.force_x     = f;
    w.force_y     = ~f;
    w.force_z     = f;
    w.noise_x     = n;
    w.noise_y     = ~n;
    w.noise_z     = n;
    return w;
  endfunction

  // valid stays up across back-to-back words, dropped only for a gap
  task automatic send_word(input lbs_pkg::in_item_t w);
    int gap;
    gap = send_idle ? $urandom_range(7) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
  endtask

  // hold off until every predicted result word is back and the core is quiet
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [lbs_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input logic [31:0] ks, hdt, dec, ns, hm, sx, sy, sz);
    cfg_write(lbs_pkg::REG_KICK_SCALE, ks);
    cfg_write(lbs_pkg::REG_HALF_DT, hdt);
    cfg_write(lbs_pkg::REG_DECAY, dec);
    cfg_write(lbs_pkg::REG_NOISE_SCALE, ns);
    cfg_write(lbs_pkg::REG_HALF_MASS, hm);
    cfg_write(lbs_pkg::REG_START_X, sx);
    cfg_write(lbs_pkg::REG_START_Y, sy);
    cfg_write(lbs_pkg::REG_START_Z, sz);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_moderate_settings();
    apply_settings($urandom_range(0, 8192), $urandom_range(0, 65536), $urandom(),
                   $urandom_range(0, 65536), $urandom_range(0, 32'h0010_0000),
                   pick_q16(), pick_q16(), pick_q16());
  endtask

  // trajectories: start, a run of steps, mostly a close; some stray words
  task automatic run_episodes(input int words);
    int sent;
    int steps;
    sent = 0;
    while (sent < words) begin
      send_idle <= ($urandom_range(3) != 0);
      take_idle <= ($urandom_range(3) != 0);
      if ($urandom_range(9) == 0) begin
        send_word(random_word(2'($urandom_range(3))));
        sent++;
      end else begin
        send_word(random_word(lbs_pkg::ACT_START));
        steps = $urandom_range(1, 12);
        repeat (steps) send_word(random_word(lbs_pkg::ACT_STEP));
        sent += steps + 1;
        if ($urandom_range(3) != 0) begin
          send_word(random_word(lbs_pkg::ACT_CLOSE));
          sent++;
        end
      end
      if ($urandom_range(15) == 0)
        wait_drained();
    end
  endtask

  // result side: random stall per word, ready held between words otherwise
  initial begin : result_side
    int hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = take_idle ? $urandom_range(7) : 0;
      if (hold > 0) begin
        result_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed words at reset settings, no idling
    send_word(random_word(ACT_UNUSED));
    send_word(random_word(lbs_pkg::ACT_CLOSE));
    send_word(directed_word(lbs_pkg::ACT_STEP, 32'h0, 32'h0, 16'h0));
    send_word(directed_word(lbs_pkg::ACT_STEP, 32'h0, 32'h7FFF_FFFF, 16'h7FFF));
    send_word(random_word(ACT_UNUSED));
    send_word(directed_word(lbs_pkg::ACT_CLOSE, 32'h0, 32'h8000_0000, 16'h0));
    send_word(random_word(lbs_pkg::ACT_CLOSE));
    send_word(directed_word(lbs_pkg::ACT_START, 32'h7FFF_FFFF, 32'h0, 16'h0));
    send_word(directed_word(lbs_pkg::ACT_STEP, 32'h0, 32'h7FFF_FFFF, 16'h8000));
    send_word(directed_word(lbs_pkg::ACT_STEP, 32'h0, 32'h0, 16'h0));
    send_word(directed_word(lbs_pkg::ACT_START, 32'h0, 32'h0, 16'h0));
    send_word(random_word(lbs_pkg::ACT_STEP));
    send_word(directed_word(lbs_pkg::ACT_START, 32'hFFFF_FFFF, 32'h0, 16'h0));
    send_word(directed_word(lbs_pkg::ACT_STEP, 32'h0, 32'h0001_0000, 16'h1000));
    send_word(random_word(lbs_pkg::ACT_STEP));
    send_word(random_word(lbs_pkg::ACT_CLOSE));
    send_word(random_word(lbs_pkg::ACT_START));
    send_word(random_word(lbs_pkg::ACT_STEP));
    send_word(random_word(lbs_pkg::ACT_CLOSE));
    wait_drained();

    // reset settings, random trajectories
    run_episodes(300);
    wait_drained();

    // moderate physical settings
    apply_moderate_settings();
    run_episodes(400);
    wait_drained();

    // scale registers at their top value, start positions at the signed extremes and -1
    apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    run_episodes(250);
    wait_drained();

    // every register cleared
    apply_settings(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    run_episodes(250);
    wait_drained();

    // arbitrary patterns
    apply_settings($urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom(), $urandom());
    run_episodes(250);
    wait_drained();

    apply_moderate_settings();
    run_episodes(380);
    wait_drained();

    if (errors == 0 && outstanding == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
